[rtl/wvft_pkg.sv]
// ----------------------------------------------------------------------------
// wvft_pkg: shared types, constants and functions
// Beat formats, CORDIC cell payload, angle constants and arctangent table
// for the world-to-vehicle frame transform.
// ----------------------------------------------------------------------------
package wvft_pkg;

  localparam int unsigned HEADING_W          = 26;
  localparam int unsigned COORD_W            = 32;
  localparam int unsigned DIFF_W             = COORD_W + 1;
  localparam int unsigned CS_W               = 32;
  localparam int unsigned Z_W                = 25;
  localparam int unsigned ANG_W              = 27;
  localparam int unsigned COEF_W             = 31;
  localparam int unsigned PROD_W             = 64;
  localparam int unsigned SUM_W              = PROD_W + 1;
  localparam int unsigned FRAC_SHIFT         = 28;
  localparam int unsigned LOC_W              = SUM_W - FRAC_SHIFT;
  localparam int unsigned CM_W               = LOC_W + 7;
  localparam int unsigned SAT_IN_W           = 48;
  localparam int unsigned ATAN_ENTRIES       = 24;
  localparam int unsigned TRIG_ITERATIONS_DEF = 16;

  localparam logic signed [ANG_W-1:0] DEG360 = 27'sd23592960;
  localparam logic signed [ANG_W-1:0] DEG180 = 27'sd11796480;
  localparam logic signed [ANG_W-1:0] DEG90  = 27'sd5898240;

  localparam logic signed [CS_W-1:0]   CORDIC_K  = 32'sd652032874;
  localparam logic signed [SUM_W-1:0]  ROUND_ADD = 65'sd134217728;
  localparam logic signed [CM_W-1:0]   CM_SCALE  = 44'sd100;

  localparam logic signed [SAT_IN_W-1:0] SAT_MAX = 48'sd2147483647;
  localparam logic signed [SAT_IN_W-1:0] SAT_MIN = -48'sd2147483648;

  typedef struct packed {
    logic signed [HEADING_W-1:0] heading_deg;
    logic signed [COORD_W-1:0]   vehicle_x;
    logic signed [COORD_W-1:0]   vehicle_y;
    logic signed [COORD_W-1:0]   point_x;
    logic signed [COORD_W-1:0]   point_y;
  } in_beat_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] local_x_m;
    logic signed [COORD_W-1:0] local_y_m;
    logic signed [COORD_W-1:0] local_x_cm;
    logic signed [COORD_W-1:0] local_y_cm;
  } out_beat_t;

  typedef struct packed {
    logic                     neg;
    logic signed [CS_W-1:0]   x;
    logic signed [CS_W-1:0]   y;
    logic signed [Z_W-1:0]    z;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
  } cell_t;

  function automatic logic signed [Z_W-1:0] atan_deg(input int unsigned idx);
    logic signed [Z_W-1:0] r;
    case (idx)
      0:  r = 25'sd2949120;
      1:  r = 25'sd1740967;
      2:  r = 25'sd919879;
      3:  r = 25'sd466945;
      4:  r = 25'sd234379;
      5:  r = 25'sd117304;
      6:  r = 25'sd58666;
      7:  r = 25'sd29335;
      8:  r = 25'sd14668;
      9:  r = 25'sd7334;
      10: r = 25'sd3667;
      11: r = 25'sd1833;
      12: r = 25'sd917;
      13: r = 25'sd458;
      14: r = 25'sd229;
      15: r = 25'sd115;
      16: r = 25'sd57;
      17: r = 25'sd29;
      18: r = 25'sd14;
      19: r = 25'sd7;
      20: r = 25'sd4;
      21: r = 25'sd2;
      22: r = 25'sd1;
      default: r = 25'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[COORD_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/world_to_vehicle_frame_transform.sv]
// Throughput: one beat per cycle while not halted; the whole pipeline advances together.
// The pipeline halts only while an output beat waits under out_stall_i.
// Reset clears every stage valid bit asynchronously; payload is not reset.
// ----------------------------------------------------------------------------
// world_to_vehicle_frame_transform: inverse 2D rigid transform
// Subtracts the vehicle position from the marker and rotates by the negative
// heading, using a chain of CORDIC cells for sine and cosine in degrees.
// ----------------------------------------------------------------------------
module world_to_vehicle_frame_transform #(
  parameter int unsigned TRIG_ITERATIONS = wvft_pkg::TRIG_ITERATIONS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  wvft_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output wvft_pkg::out_beat_t out_beat_o
);

  localparam int unsigned NCELL = (TRIG_ITERATIONS > wvft_pkg::ATAN_ENTRIES) ?
                                  wvft_pkg::ATAN_ENTRIES : TRIG_ITERATIONS;

  logic            en;
  logic            chain_valid [NCELL+1];
  wvft_pkg::cell_t chain       [NCELL+1];

  assign in_stall_o = out_valid_o && out_stall_i;
  assign en         = !in_stall_o;

  wvft_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .beat_i  (in_beat_i),
    .valid_o (chain_valid[0]),
    .cell_o  (chain[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    wvft_cordic_cell #(
      .STEP (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_valid[i]),
      .cell_i  (chain[i]),
      .valid_o (chain_valid[i+1]),
      .cell_o  (chain[i+1])
    );
  end

  wvft_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (chain_valid[NCELL]),
    .cell_i  (chain[NCELL]),
    .valid_o (out_valid_o),
    .beat_o  (out_beat_o)
  );

`ifndef SYNTHESIS
  a_hold_on_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> out_valid_o && $stable(out_beat_o))
    else $error("output beat changed while pipeline halted");

  a_sign_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_beat_o.local_x_m[31] == out_beat_o.local_x_cm[31])
    else $error("x metre and centimetre signs differ");

  a_sign_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_beat_o.local_y_m[31] == out_beat_o.local_y_cm[31])
    else $error("y metre and centimetre signs differ");

  a_sat_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.local_x_m == 32'sh7fffffff
    |-> out_beat_o.local_x_cm == 32'sh7fffffff)
    else $error("x centimetres not saturated with metres");
`endif

endmodule

[rtl/wvft_prep.sv]
// ----------------------------------------------------------------------------
// wvft_prep: angle reduction and position difference
// Stage one reduces the heading into (-180, 180] and forms dx, dy; stage two
// folds the angle into [-90, 90] and seeds the first CORDIC cell.
// ----------------------------------------------------------------------------
module wvft_prep (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  wvft_pkg::in_beat_t beat_i,
  output logic               valid_o,
  output wvft_pkg::cell_t    cell_o
);

  logic                                     red_valid_q;
  logic signed [wvft_pkg::Z_W-1:0]          red_d, red_q;
  logic signed [wvft_pkg::DIFF_W-1:0]       dx_d, dx_q, dy_d, dy_q;
  logic signed [wvft_pkg::ANG_W-1:0]        h_ext, h_red, a_ext, a_fold;
  logic                                     valid_q;
  wvft_pkg::cell_t                          cell_d, cell_q;

  always_comb begin
    h_ext = {beat_i.heading_deg[wvft_pkg::HEADING_W-1], beat_i.heading_deg};
    if (h_ext > wvft_pkg::DEG180) begin
      h_red = h_ext - wvft_pkg::DEG360;
    end else if (h_ext <= -wvft_pkg::DEG180) begin
      h_red = h_ext + wvft_pkg::DEG360;
    end else begin
      h_red = h_ext;
    end
    red_d = h_red[wvft_pkg::Z_W-1:0];
    dx_d  = {beat_i.point_x[wvft_pkg::COORD_W-1], beat_i.point_x}
          - {beat_i.vehicle_x[wvft_pkg::COORD_W-1], beat_i.vehicle_x};
    dy_d  = {beat_i.point_y[wvft_pkg::COORD_W-1], beat_i.point_y}
          - {beat_i.vehicle_y[wvft_pkg::COORD_W-1], beat_i.vehicle_y};
  end

  always_comb begin
    a_ext = {{(wvft_pkg::ANG_W-wvft_pkg::Z_W){red_q[wvft_pkg::Z_W-1]}}, red_q};
    cell_d.neg = 1'b0;
    if (a_ext > wvft_pkg::DEG90) begin
      a_fold     = a_ext - wvft_pkg::DEG180;
      cell_d.neg = 1'b1;
    end else if (a_ext < -wvft_pkg::DEG90) begin
      a_fold     = a_ext + wvft_pkg::DEG180;
      cell_d.neg = 1'b1;
    end else begin
      a_fold = a_ext;
    end
    cell_d.z  = a_fold[wvft_pkg::Z_W-1:0];
    cell_d.x  = wvft_pkg::CORDIC_K;
    cell_d.y  = '0;
    cell_d.dx = dx_q;
    cell_d.dy = dy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_valid_q <= 1'b0;
      valid_q     <= 1'b0;
    end else if (en_i) begin
      red_valid_q <= valid_i;
      valid_q     <= red_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      red_q  <= red_d;
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      cell_q <= cell_d;
    end
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;

endmodule

[rtl/wvft_cordic_cell.sv]
// ----------------------------------------------------------------------------
// wvft_cordic_cell: one rotation step of the CORDIC chain
// Rotates (x, y) by plus or minus atan(2^-STEP) degrees towards z = 0 and
// hands the result and the carried differences to the next cell.
// ----------------------------------------------------------------------------
module wvft_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  wvft_pkg::cell_t cell_i,
  output logic            valid_o,
  output wvft_pkg::cell_t cell_o
);

  localparam logic signed [wvft_pkg::Z_W-1:0] ATAN = wvft_pkg::atan_deg(STEP);

  logic signed [wvft_pkg::CS_W-1:0] x, y, xs, ys;
  logic                             valid_q;
  wvft_pkg::cell_t                  cell_d, cell_q;

  always_comb begin
    x      = cell_i.x;
    y      = cell_i.y;
    xs     = x >>> STEP;
    ys     = y >>> STEP;
    cell_d = cell_i;
    if (!cell_i.z[wvft_pkg::Z_W-1]) begin
      cell_d.x = x - ys;
      cell_d.y = y + xs;
      cell_d.z = cell_i.z - ATAN;
    end else begin
      cell_d.x = x + ys;
      cell_d.y = y - xs;
      cell_d.z = cell_i.z + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;

endmodule

[rtl/wvft_rotate.sv]
// ----------------------------------------------------------------------------
// wvft_rotate: coefficient rounding, rotation and unit scaling
// Rounds sine and cosine to Q28, forms the four products, sums and rounds to
// Q16.16, scales to centimetres and saturates into the output register.
// ----------------------------------------------------------------------------
module wvft_rotate (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  wvft_pkg::cell_t     cell_i,
  output logic                valid_o,
  output wvft_pkg::out_beat_t beat_o
);

  logic [4:0]                            valid_q;
  logic signed [wvft_pkg::CS_W:0]        xn, yn, xr, yr;
  logic signed [wvft_pkg::COEF_W-1:0]    c_q, s_q;
  logic signed [wvft_pkg::DIFF_W-1:0]    dx_q, dy_q;
  logic signed [wvft_pkg::PROD_W-1:0]    cdx_q, sdy_q, cdy_q, sdx_q;
  logic signed [wvft_pkg::SUM_W-1:0]     sum_x, sum_y;
  logic signed [wvft_pkg::LOC_W-1:0]     lx_q, ly_q;
  logic signed [wvft_pkg::COORD_W-1:0]   mx_q, my_q;
  logic signed [wvft_pkg::CM_W-1:0]      cmx_q, cmy_q;
  wvft_pkg::out_beat_t                   beat_q;

  always_comb begin
    xn = {cell_i.x[wvft_pkg::CS_W-1], cell_i.x};
    yn = {cell_i.y[wvft_pkg::CS_W-1], cell_i.y};
    if (cell_i.neg) begin
      xn = -xn;
      yn = -yn;
    end
    xr = xn + 33'sd2;
    yr = yn + 33'sd2;
    sum_x = {cdx_q[wvft_pkg::PROD_W-1], cdx_q} + {sdy_q[wvft_pkg::PROD_W-1], sdy_q}
          + wvft_pkg::ROUND_ADD;
    sum_y = {cdy_q[wvft_pkg::PROD_W-1], cdy_q} - {sdx_q[wvft_pkg::PROD_W-1], sdx_q}
          + wvft_pkg::ROUND_ADD;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q   <= xr[wvft_pkg::CS_W:2];
      s_q   <= yr[wvft_pkg::CS_W:2];
      dx_q  <= cell_i.dx;
      dy_q  <= cell_i.dy;
      cdx_q <= 64'(c_q) * 64'(dx_q);
      sdy_q <= 64'(s_q) * 64'(dy_q);
      cdy_q <= 64'(c_q) * 64'(dy_q);
      sdx_q <= 64'(s_q) * 64'(dx_q);
      lx_q  <= sum_x[wvft_pkg::SUM_W-1:wvft_pkg::FRAC_SHIFT];
      ly_q  <= sum_y[wvft_pkg::SUM_W-1:wvft_pkg::FRAC_SHIFT];
      mx_q  <= wvft_pkg::sat32(48'(lx_q));
      my_q  <= wvft_pkg::sat32(48'(ly_q));
      cmx_q <= 44'(lx_q) * wvft_pkg::CM_SCALE;
      cmy_q <= 44'(ly_q) * wvft_pkg::CM_SCALE;
      beat_q.local_x_m  <= mx_q;
      beat_q.local_y_m  <= my_q;
      beat_q.local_x_cm <= wvft_pkg::sat32(48'(cmx_q));
      beat_q.local_y_cm <= wvft_pkg::sat32(48'(cmy_q));
    end
  end

  assign valid_o = valid_q[4];
  assign beat_o  = beat_q;

endmodule
